[rtl/tkns_pkg.sv]
// Shared types and constants for the top-k nearest selector.
package tkns_pkg;
    localparam int DEF_MAX_K = 16;
    localparam int SCORE_W   = 32;
    localparam int KEY_W     = 32;
    localparam int KCFG_W    = 5;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_OFFER        = 2'd0;
    localparam logic [OP_W-1:0] OP_OFFER_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH       = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD         = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic offer;
        logic emit_start;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic emit_done;
        logic emit_empty;
    } t_status;
endpackage

[rtl/tkns_ctrl.sv]
// Controller state machine: accepts requests and sequences the emit phase.
module tkns_ctrl
    import tkns_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_operation,
    input  t_status         i_status,
    output t_cmd            o_cmd,
    output logic            o_busy
);
    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.offer      = 1'b0;
        o_cmd.emit_start = 1'b0;
        o_cmd.emit_step  = 1'b0;
        o_busy           = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.offer = (i_operation == OP_OFFER) ||
                                  (i_operation == OP_OFFER_FINISH);
                    if (i_operation == OP_OFFER_FINISH || i_operation == OP_FINISH) begin
                        o_cmd.emit_start = 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                o_busy = 1'b1;
                if (i_status.emit_empty || i_status.emit_done) begin
                    n_state = S_IDLE;
                end
                if (!i_status.emit_empty) begin
                    o_cmd.emit_step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/tkns_dp.sv]
// Datapath: sorted survivor store with parallel insert and serial emit.
module tkns_dp
    import tkns_pkg::*;
#(
    parameter int MAX_K = DEF_MAX_K
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [KCFG_W-1:0]  i_keep_count,
    input  logic [SCORE_W-1:0] i_score,
    input  logic [KEY_W-1:0]   i_key,
    output t_status            o_status,
    output logic               o_valid,
    output logic [SCORE_W-1:0] o_out_score,
    output logic [KEY_W-1:0]   o_out_key,
    output logic               o_last
);
    localparam int CW = $clog2(MAX_K + 1);
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int LW = (CW > KCFG_W) ? CW : KCFG_W;

    logic [SCORE_W-1:0] r_score [MAX_K];
    logic [KEY_W-1:0]   r_key   [MAX_K];
    logic [CW-1:0]      r_total;
    logic [CW-1:0]      r_emit_n;
    logic [CW-1:0]      r_idx;
    logic               r_valid;
    logic [SCORE_W-1:0] r_oscore;
    logic [KEY_W-1:0]   r_okey;
    logic               r_olast;

    logic [LW-1:0] w_lim;
    logic [CW-1:0] w_limc;
    logic [CW-1:0] w_base;
    logic          w_ins;
    logic [MAX_K-1:0] w_before;
    logic [CW-1:0] w_nxt_total;
    logic [CW-1:0] w_emit_n;

    function automatic logic before_f(input logic [SCORE_W-1:0] sa, input logic [KEY_W-1:0] ka,
                                      input logic [SCORE_W-1:0] sb, input logic [KEY_W-1:0] kb);
        if (sa != sb) return sa < sb;
        return $signed(ka) < $signed(kb);
    endfunction

    always_comb begin
        if (LW'(i_keep_count) > LW'(MAX_K)) w_lim = LW'(MAX_K);
        else                                w_lim = LW'(i_keep_count);
        w_limc = CW'(w_lim);
        for (int i = 0; i < MAX_K; i++) begin
            w_before[i] = before_f(i_score, i_key, r_score[i], r_key[i]);
        end
        w_ins  = 1'b0;
        w_base = r_total;
        if (r_total < w_limc) begin
            w_ins = 1'b1;
        end else if (r_total != '0) begin
            w_base = r_total - CW'(1);
            w_ins  = w_before[IW'(w_base)];
        end
        // count after an offer in the same request
        w_nxt_total = (i_cmd.offer && r_total < w_limc) ? r_total + CW'(1) : r_total;
        w_emit_n    = (w_nxt_total > w_limc) ? w_limc : w_nxt_total;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.offer && w_ins) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (CW'(i) <= w_base) begin
                    if (w_before[i]) begin
                        if (i == 0 || !w_before[(i == 0) ? 0 : i-1]) begin
                            r_score[i] <= i_score;
                            r_key[i]   <= i_key;
                        end else begin
                            r_score[i] <= r_score[(i == 0) ? 0 : i-1];
                            r_key[i]   <= r_key[(i == 0) ? 0 : i-1];
                        end
                    end else if (CW'(i) == w_base && (i == 0 || !w_before[(i == 0) ? 0 : i-1])) begin
                        r_score[i] <= i_score;
                        r_key[i]   <= i_key;
                    end else if (CW'(i) == w_base) begin
                        r_score[i] <= r_score[(i == 0) ? 0 : i-1];
                        r_key[i]   <= r_key[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
        r_oscore <= r_score[IW'(r_idx)];
        r_okey   <= r_key[IW'(r_idx)];
        r_olast  <= (r_idx + CW'(1) == r_emit_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_emit_n <= '0;
            r_idx    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_step;
            if (i_cmd.emit_start) begin
                r_idx <= '0;
            end else if (i_cmd.emit_step) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.offer && w_ins && r_total < w_limc) begin
                r_total <= r_total + CW'(1);
            end
            // emit runs from r_emit_n, so the store empties at the finish request
            if (i_cmd.emit_start) begin
                r_emit_n <= w_emit_n;
                r_total  <= '0;
            end
        end
    end

    assign o_status.emit_empty = (r_emit_n == '0) && !r_valid && (r_idx == '0);
    assign o_status.emit_done  = (r_idx + CW'(1) == r_emit_n);
    assign o_valid     = r_valid;
    assign o_out_score = r_oscore;
    assign o_out_key   = r_okey;
    assign o_last      = r_olast;
endmodule

[rtl/top_k_nearest_selector_unit.sv]
// Top level: keeps the k best (score, key) candidates and emits them in order.
// Back-to-back offers are accepted every cycle while busy is low. A finish
// holds busy until its n results are out, one per cycle; n = min(kept, k).
// Synchronous active-low reset clears the kept count and sets k to 16.
module top_k_nearest_selector_unit
    import tkns_pkg::*;
#(
    parameter int MAX_K = DEF_MAX_K
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [KCFG_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [SCORE_W-1:0] i_score,
    input  logic [KEY_W-1:0]   i_key,
    output logic               o_strobe,
    output logic [SCORE_W-1:0] o_out_score,
    output logic [KEY_W-1:0]   o_out_key,
    output logic               o_last
);
    logic [KCFG_W-1:0] r_keep_count;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= KCFG_W'(16);
        end else if (i_cfg_we) begin
            r_keep_count <= i_cfg_wdata;
        end
    end

    tkns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start && !o_strobe),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_busy      (w_busy)
    );

    tkns_dp #(.MAX_K(MAX_K)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_keep_count (r_keep_count),
        .i_score      (i_score),
        .i_key        (i_key),
        .o_status     (w_status),
        .o_valid      (o_strobe),
        .o_out_score  (o_out_score),
        .o_out_key    (o_out_key),
        .o_last       (o_last)
    );

    assign busy = w_busy || o_strobe;
endmodule

[tb/tb_top_k_nearest_selector_unit.sv]
// Testbench for the top-k nearest selector: directed table, then random bursts.
`timescale 1ns / 1ps

module tb_top_k_nearest_selector_unit;
    import tkns_pkg::*;

    localparam int KMAX = DEF_MAX_K;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
    } t_req;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
        logic               last;
    } t_surv;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic [KCFG_W-1:0]  i_cfg_wdata = '0;
    logic [OP_W-1:0]    i_operation = OP_OFFER;
    logic [SCORE_W-1:0] i_score = '0;
    logic [KEY_W-1:0]   i_key = '0;
    logic               o_strobe;
    logic [SCORE_W-1:0] o_out_score;
    logic [KEY_W-1:0]   o_out_key;
    logic               o_last;

    top_k_nearest_selector_unit dut (.*);

    always #1 i_clk = ~i_clk;

    logic [SCORE_W-1:0] kept_s [KMAX];
    logic [KEY_W-1:0]   kept_k [KMAX];
    int                 kept_n;
    int                 k_cfg;
    t_surv              pending_q[$];
    int                 errors;

    function automatic bit closer(logic [31:0] sa, logic [31:0] ka,
                                  logic [31:0] sb, logic [31:0] kb);
        if (sa != sb) return sa < sb;
        return $signed(ka) < $signed(kb);
    endfunction

    function automatic int k_eff();
        return (k_cfg > KMAX) ? KMAX : k_cfg;
    endfunction

    function automatic void admit(logic [31:0] s, logic [31:0] k);
        int pos;
        if (kept_n >= k_eff()) begin
            if (kept_n == 0 || kept_n > KMAX) return;
            if (!closer(s, k, kept_s[kept_n-1], kept_k[kept_n-1])) return;
            kept_n--;
        end
        pos = kept_n;
        while (pos > 0 && closer(s, k, kept_s[pos-1], kept_k[pos-1])) begin
            kept_s[pos] = kept_s[pos-1];
            kept_k[pos] = kept_k[pos-1];
            pos--;
        end
        kept_s[pos] = s;
        kept_k[pos] = k;
        kept_n++;
    endfunction

    function automatic void predict_survivors(t_req r);
        int n;
        t_surv e;
        if (r.op == OP_OFFER || r.op == OP_OFFER_FINISH) admit(r.score, r.key);
        if (r.op == OP_OFFER_FINISH || r.op == OP_FINISH) begin
            n = (kept_n > k_eff()) ? k_eff() : kept_n;
            for (int i = 0; i < n; i++) begin
                e.score = kept_s[i];
                e.key   = kept_k[i];
                e.last  = (i == n - 1);
                pending_q.insert(pending_q.size(), e);
            end
            kept_n = 0;
        end
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_surv e;
        if (i_rst_n && o_strobe) begin
            if (pending_q.size() == 0) begin
                report("unexpected result", o_out_score, 0);
            end else begin
                e = pending_q.pop_front();
                if (o_out_score !== e.score) report("score", o_out_score, e.score);
                if (o_out_key !== e.key) report("key", o_out_key, e.key);
                if (o_last !== e.last) report("last", o_last, e.last);
            end
        end
    end

    // start stays high after acceptance; the caller drops it before idling
    task automatic send(t_req r);
        i_operation <= r.op;
        i_score     <= r.score;
        i_key       <= r.key;
        start       <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_survivors(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_k(int v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[KCFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        k_cfg = v;
    endtask

    function automatic t_req rand_req(int keyspan);
        t_req r;
        int p;
        p = $urandom_range(99);
        r.op    = (p < 80) ? OP_OFFER : (p < 90) ? OP_OFFER_FINISH : (p < 98) ? OP_FINISH : OP_RSVD;
        r.score = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
        r.key   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(keyspan) - keyspan / 2;
        return r;
    endfunction

    t_req dir_tab [] = '{
        '{OP_FINISH,       32'h0,        32'h0},
        '{OP_OFFER,        32'hFFFFFFFF, 32'h7FFFFFFF},
        '{OP_OFFER,        32'h0,        32'h80000000},
        '{OP_OFFER,        32'h5,        32'h3},
        '{OP_OFFER,        32'h5,        32'hFFFFFFFD},
        '{OP_RSVD,         32'h1,        32'h1},
        '{OP_OFFER_FINISH, 32'h5,        32'h0},
        '{OP_FINISH,       32'h0,        32'h0},
        '{OP_OFFER,        32'h9,        32'h1},
        '{OP_OFFER,        32'h9,        32'h1},
        '{OP_OFFER,        32'h9,        32'h0},
        '{OP_OFFER,        32'h8,        32'h7},
        '{OP_OFFER,        32'hA,        32'h0},
        '{OP_FINISH,       32'h0,        32'h0}
    };

    initial begin
        t_surv e;
        errors = 0;
        kept_n = 0;
        k_cfg  = 16;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(dir_tab[0]);
        send(dir_tab[1]);
        send(dir_tab[2]);
        // known answer for the two extremes
        send('{OP_FINISH, 32'h0, 32'h0});
        if (pending_q.size() != 2 || pending_q[0].score != 32'h0
            || pending_q[1].score != 32'hFFFFFFFF || pending_q[1].last != 1'b1)
            report("directed extremes", pending_q.size(), 2);
        drain();
        for (int i = 3; i < 8; i++) send(dir_tab[i]);
        set_k(2);
        for (int i = 8; i < dir_tab.size(); i++) send(dir_tab[i]);
        set_k(0);
        send(dir_tab[1]);
        send('{OP_OFFER_FINISH, 32'h3, 32'h3});
        set_k(3);
        for (int i = 0; i < 3; i++) send('{OP_OFFER, 32'(i), 32'(i)});
        set_k(1);
        send('{OP_OFFER, 32'h0, 32'hFFFFFFFF});
        send('{OP_FINISH, 32'h0, 32'h0});
        set_k(31);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: set_k(0);
                2: set_k(1);
                3: set_k(5);
                4: set_k(16);
                5: set_k($urandom_range(17, 31));
                default: ;
            endcase
            for (int n = 0; n < 80; ) begin
                int burst;
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 80; b++, n++)
                    send(rand_req(ph == 3 ? 8 : 200));
                if ($urandom_range(1)) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                end
                if (n == 40 && ph == 2) drain();
            end
            send('{OP_FINISH, 32'h0, 32'h0});
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            while (pending_q.size() != 0) begin
                e = pending_q.pop_front();
                report("missing result", e.score, e.key);
            end
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
